// File: rtl/core/mtac_pkg.sv
// Package: shared types and constants of the Modbus TCP ADU checker.
`timescale 1ns / 1ps
`default_nettype none

package mtac_pkg;

	// Frame status codes reported on the final byte
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TRUNC    = 2'd1,
		ST_BADLEN   = 2'd2,
		ST_BADPROTO = 2'd3
	} status_t;

	// Header byte positions (big-endian MBAP header)
	localparam logic [8:0] POS_TID_HI   = 9'd0;
	localparam logic [8:0] POS_TID_LO   = 9'd1;
	localparam logic [8:0] POS_PROTO_HI = 9'd2;
	localparam logic [8:0] POS_PROTO_LO = 9'd3;
	localparam logic [8:0] POS_LEN_HI   = 9'd4;
	localparam logic [8:0] POS_LEN_LO   = 9'd5;
	localparam logic [8:0] POS_UNIT     = 9'd6;

	localparam logic [8:0]  HDR_BYTES  = 9'd7;
	localparam logic [8:0]  POS_SAT    = 9'd511;
	localparam logic [16:0] LEN_OFFSET = 17'd6;
	localparam logic [15:0] MIN_LENGTH = 16'd2;

	localparam int MAX_ADU_BYTES_DEF = 260;

	// One received frame byte
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} in_t;

	// One result per received byte
	typedef struct packed {
		logic [7:0]  pdu_byte;
		logic        pdu_byte_valid;
		logic        frame_done;
		status_t     frame_status;
		logic [15:0] trans_id;
		logic [7:0]  unit_id;
		logic [8:0]  pdu_length;
	} out_t;

endpackage

`default_nettype wire

// File: rtl/core/mtac_frame_eval.sv
// Frame tracker: byte position, header captures and per-byte result logic.
`timescale 1ns / 1ps
`default_nettype none

module mtac_frame_eval #(
	parameter int MAX_ADU_BYTES = mtac_pkg::MAX_ADU_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         adv,
	input  wire mtac_pkg::in_t  item,
	output mtac_pkg::out_t    res
);

	logic [8:0]  pos_q;
	logic [15:0] tid_q;
	logic [15:0] proto_q;
	logic [15:0] len_q;
	logic [7:0]  unit_q;

	logic [15:0] tid_n;
	logic [15:0] proto_n;
	logic [15:0] len_n;
	logic [7:0]  unit_n;
	logic [8:0]  count;
	logic [16:0] expected;
	logic        fwd;
	mtac_pkg::status_t status;

	// Merge this byte into the header field it belongs to
	always_comb begin
		tid_n   = tid_q;
		proto_n = proto_q;
		len_n   = len_q;
		unit_n  = unit_q;
		unique case (pos_q)
			mtac_pkg::POS_TID_HI:   tid_n[15:8]   = item.frame_byte;
			mtac_pkg::POS_TID_LO:   tid_n[7:0]    = item.frame_byte;
			mtac_pkg::POS_PROTO_HI: proto_n[15:8] = item.frame_byte;
			mtac_pkg::POS_PROTO_LO: proto_n[7:0]  = item.frame_byte;
			mtac_pkg::POS_LEN_HI:   len_n[15:8]   = item.frame_byte;
			mtac_pkg::POS_LEN_LO:   len_n[7:0]    = item.frame_byte;
			mtac_pkg::POS_UNIT:     unit_n        = item.frame_byte;
			default: ;
		endcase
	end

	// Forward by position; saturate the byte count
	assign expected = mtac_pkg::LEN_OFFSET + {1'b0, len_n};
	assign fwd = (pos_q >= mtac_pkg::HDR_BYTES) && (pos_q < mtac_pkg::POS_SAT) &&
		({8'd0, pos_q} < expected);
	assign count = (pos_q == mtac_pkg::POS_SAT) ? mtac_pkg::POS_SAT : pos_q + 9'd1;

	// Check the frame in order of precedence
	always_comb begin
		priority if (count < mtac_pkg::HDR_BYTES) begin
			status = mtac_pkg::ST_TRUNC;
		end else if (proto_n != 16'd0) begin
			status = mtac_pkg::ST_BADPROTO;
		end else if ((len_n < mtac_pkg::MIN_LENGTH) || (expected > 17'(MAX_ADU_BYTES))) begin
			status = mtac_pkg::ST_BADLEN;
		end else if ({8'd0, count} < expected) begin
			status = mtac_pkg::ST_TRUNC;
		end else if ({8'd0, count} > expected) begin
			status = mtac_pkg::ST_BADLEN;
		end else begin
			status = mtac_pkg::ST_OK;
		end
	end

	// Build the result; frame fields show only on the final byte
	always_comb begin
		res.pdu_byte       = fwd ? item.frame_byte : 8'd0;
		res.pdu_byte_valid = fwd;
		res.frame_done     = item.frame_end;
		res.frame_status   = mtac_pkg::ST_OK;
		res.trans_id       = 16'd0;
		res.unit_id        = 8'd0;
		res.pdu_length     = 9'd0;
		if (item.frame_end) begin
			res.frame_status   = status;
			res.trans_id       = tid_n;
			res.unit_id        = unit_n;
			if (status == mtac_pkg::ST_OK) begin
				res.pdu_length = 9'(len_n - 16'd1);
			end
		end
	end

	// Advance the frame state; clear it at each frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			tid_q   <= '0;
			proto_q <= '0;
			len_q   <= '0;
			unit_q  <= '0;
		end else if (adv) begin
			if (item.frame_end) begin
				pos_q   <= '0;
				tid_q   <= '0;
				proto_q <= '0;
				len_q   <= '0;
				unit_q  <= '0;
			end else begin
				pos_q   <= count;
				tid_q   <= tid_n;
				proto_q <= proto_n;
				len_q   <= len_n;
				unit_q  <= unit_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/modbus_tcp_adu_checker_core.sv
// Top level: Modbus TCP ADU checker with input and result registers.
`timescale 1ns / 1ps
`default_nettype none

// Takes one Modbus TCP frame byte per transfer and returns one result per byte.
// The 7-byte MBAP header is captured, bytes 7 through 5+length are forwarded as
// PDU bytes, and the byte marked frame_end carries the frame status, transaction
// id, unit id and PDU length. Sustained rate is one byte per clock while the
// receiver takes every result; a byte is held in the input register and its
// result in the result register, and a stall on result_ready holds both. The
// rate is set by the update of the byte position counter and header capture
// registers between the input register and the result register. Forwarded
// bytes are flagged valid by position alone, whatever their frame's status.
module modbus_tcp_adu_checker_core #(
	parameter int MAX_ADU_BYTES = mtac_pkg::MAX_ADU_BYTES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           byte_valid,
	output logic                byte_ready,
	input  wire mtac_pkg::in_t  byte_data,
	output logic                result_valid,
	input  wire logic           result_ready,
	output mtac_pkg::out_t      result_data
);

	logic            valid_s1;
	mtac_pkg::in_t   item_s1;
	logic            adv;
	mtac_pkg::out_t  res;
	logic            res_valid_q;
	mtac_pkg::out_t  res_q;

	// Move stage 1 forward when the result register is free or draining
	assign adv        = valid_s1 && (!res_valid_q || result_ready);
	assign byte_ready = !valid_s1 || adv;

	// Hold the accepted byte in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_data;
		end
	end

	mtac_frame_eval #(
		.MAX_ADU_BYTES(MAX_ADU_BYTES)
	) u_eval (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.item  (item_s1),
		.res   (res)
	);

	// Load the result register; drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

endmodule

`default_nettype wire

// File: rtl/core/mtac_checker.sv
// Checker: port-level assertions for the ADU checker core, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module mtac_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           result_valid,
	input wire logic           result_ready,
	input wire mtac_pkg::out_t result_data
);

	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_data))
		else $error("result payload changed while stalled");

	// Non-forwarded bytes read as zero
	a_pdu_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.pdu_byte_valid |-> result_data.pdu_byte == 8'd0)
		else $error("pdu_byte not zero when not forwarded");

	// Frame fields stay zero before the final byte
	a_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.frame_done |->
			result_data.frame_status == mtac_pkg::ST_OK &&
			result_data.trans_id == 16'd0 &&
			result_data.unit_id == 8'd0 && result_data.pdu_length == 9'd0)
		else $error("frame fields set before frame end");

	// A failed frame reports no PDU length
	a_bad_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.frame_status != mtac_pkg::ST_OK |->
			result_data.pdu_length == 9'd0)
		else $error("pdu_length set on a failed frame");

endmodule

bind modbus_tcp_adu_checker_core mtac_checker u_mtac_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result_data (result_data)
);

`default_nettype wire

// File: tb/modbus_tcp_adu_checker_core_test.sv
// Testbench for the Modbus TCP ADU checker core: frame stimulus and result checks.
`timescale 1ns / 1ps

module modbus_tcp_adu_checker_core_test;

	localparam int MAX_ADU    = mtac_pkg::MAX_ADU_BYTES_DEF;
	localparam int CYCLE_STOP = 400000;
	localparam int PIPE_DRAIN = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_ready;
	mtac_pkg::in_t  byte_data = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	mtac_pkg::out_t result_data;

	// Stimulus pacing, shared with the receiver process
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_off_cycles = 0;
	int unsigned bytes_sent = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	// Frame tracking of the predictor
	logic [8:0]  rx_pos = '0;
	logic [15:0] rx_tid = '0;
	logic [15:0] rx_proto = '0;
	logic [15:0] rx_len = '0;
	logic [7:0]  rx_unit = '0;

	mtac_pkg::out_t byte_results_pending[$];

	modbus_tcp_adu_checker_core #(
		.MAX_ADU_BYTES(MAX_ADU)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data(byte_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data(result_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_STOP) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Work out the result of one frame byte and advance the frame tracking
	function automatic mtac_pkg::out_t check_frame_byte(mtac_pkg::in_t item);
		mtac_pkg::out_t    r;
		mtac_pkg::status_t st;
		logic [16:0] span;
		logic [8:0]  count;
		r = '0;
		st = mtac_pkg::ST_OK;
		case (rx_pos)
			mtac_pkg::POS_TID_HI:   rx_tid[15:8] = item.frame_byte;
			mtac_pkg::POS_TID_LO:   rx_tid[7:0] = item.frame_byte;
			mtac_pkg::POS_PROTO_HI: rx_proto[15:8] = item.frame_byte;
			mtac_pkg::POS_PROTO_LO: rx_proto[7:0] = item.frame_byte;
			mtac_pkg::POS_LEN_HI:   rx_len[15:8] = item.frame_byte;
			mtac_pkg::POS_LEN_LO:   rx_len[7:0] = item.frame_byte;
			mtac_pkg::POS_UNIT:     rx_unit = item.frame_byte;
			default: ;
		endcase
		span = 17'd6 + {1'b0, rx_len};
		if (rx_pos >= mtac_pkg::HDR_BYTES && rx_pos < mtac_pkg::POS_SAT &&
				{8'd0, rx_pos} < span) begin
			r.pdu_byte = item.frame_byte;
			r.pdu_byte_valid = 1'b1;
		end
		count = (rx_pos == mtac_pkg::POS_SAT) ? mtac_pkg::POS_SAT : rx_pos + 9'd1;
		r.frame_done = item.frame_end;
		if (item.frame_end) begin
			if (count < mtac_pkg::HDR_BYTES)
				st = mtac_pkg::ST_TRUNC;
			else if (rx_proto != 16'd0)
				st = mtac_pkg::ST_BADPROTO;
			else if (rx_len < 16'd2 || span > 17'(MAX_ADU))
				st = mtac_pkg::ST_BADLEN;
			else if ({8'd0, count} < span)
				st = mtac_pkg::ST_TRUNC;
			else if ({8'd0, count} > span)
				st = mtac_pkg::ST_BADLEN;
			r.frame_status = st;
			r.trans_id = rx_tid;
			r.unit_id = rx_unit;
			r.pdu_length = (st == mtac_pkg::ST_OK) ? 9'(rx_len - 16'd1) : 9'd0;
			// clear captures for the next frame
			rx_pos = '0;
			rx_tid = '0;
			rx_proto = '0;
			rx_len = '0;
			rx_unit = '0;
		end else begin
			rx_pos = count;
		end
		return r;
	endfunction

	// Offer one byte; return at the edge where it transfers
	task automatic send_byte(mtac_pkg::in_t item);
		mtac_pkg::out_t pred;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= item;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		pred = check_frame_byte(item);
		byte_results_pending = {byte_results_pending, pred};
		bytes_sent++;
	endtask

	// Send a frame of nbytes bytes, header first, then random payload
	task automatic send_frame(logic [15:0] tid, logic [15:0] proto, logic [15:0] len,
			logic [7:0] unit, int unsigned nbytes);
		logic [7:0] hdr [7];
		mtac_pkg::in_t item;
		hdr = '{tid[15:8], tid[7:0], proto[15:8], proto[7:0], len[15:8], len[7:0], unit};
		for (int unsigned p = 0; p < nbytes; p++) begin
			item.frame_byte = (p < 7) ? hdr[p] : 8'($urandom);
			item.frame_end = (p == nbytes - 1);
			send_byte(item);
		end
	endtask

	// Drop valid and hold the input until every result has come back
	task automatic wait_for_results();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (byte_results_pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(string field, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_cycles != 0) begin
				result_ready <= 1'b0;
				hold_off_cycles--;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Compare each result transfer with the oldest pending prediction
	always @(posedge clk) begin
		mtac_pkg::out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (byte_results_pending.size() == 0) begin
				$error("result transfer with no byte pending");
				mismatches++;
			end else begin
				want = byte_results_pending.pop_front();
				check_field("pdu_byte", want.pdu_byte, result_data.pdu_byte);
				check_field("pdu_byte_valid", want.pdu_byte_valid,
					result_data.pdu_byte_valid);
				check_field("frame_done", want.frame_done, result_data.frame_done);
				check_field("frame_status", want.frame_status, result_data.frame_status);
				check_field("trans_id", want.trans_id, result_data.trans_id);
				check_field("unit_id", want.unit_id, result_data.unit_id);
				check_field("pdu_length", want.pdu_length, result_data.pdu_length);
			end
		end
	end

	// Full header at the extremes, then short frames whose missing fields read zero
	task automatic test_short_frames();
		send_frame(16'hFFFF, 16'h0000, 16'd2, 8'hFF, 8);
		send_frame(16'h0000, 16'h0000, 16'd0, 8'h00, 1);
		send_frame(16'hA5C3, 16'h0000, 16'd0, 8'h00, 3);
		send_frame(16'h1234, 16'hFFFF, 16'hFFFF, 8'h00, 6);
	endtask

	// Protocol id other than zero wins over every later check
	task automatic test_bad_protocol();
		send_frame(16'h0101, 16'h0001, 16'd0, 8'h7E, 7);
		send_frame(16'h0202, 16'h8000, 16'd4, 8'h01, 10);
	endtask

	// Length field below the minimum and around the ADU limit
	task automatic test_length_limits();
		send_frame(16'h0001, 16'h0000, 16'd0, 8'h11, 7);
		send_frame(16'h0002, 16'h0000, 16'd1, 8'h22, 7);
		send_frame(16'hFFFE, 16'h0000, 16'(MAX_ADU - 6), 8'h33, MAX_ADU);
		send_frame(16'h0003, 16'h0000, 16'(MAX_ADU - 5), 8'h44, 9);
		send_frame(16'h0004, 16'h0000, 16'hFFFF, 8'h55, 9);
	endtask

	// Byte count one short of, one past and equal to the header length
	task automatic test_count_mismatch();
		send_frame(16'h00AA, 16'h0000, 16'd5, 8'h0A, 10);
		send_frame(16'h00BB, 16'h0000, 16'd5, 8'h0B, 12);
		send_frame(16'h00CC, 16'h0000, 16'd5, 8'h0C, 11);
	endtask

	// Frame long enough to saturate the byte position, then a well-formed frame
	task automatic test_saturated_count();
		send_frame(16'h5A5A, 16'h0000, 16'd10, 8'h99, 520);
		send_frame(16'h0007, 16'h0000, 16'd3, 8'h01, 9);
	endtask

	// Hold the receiver off while the sender keeps offering at full rate
	task automatic test_backpressure();
		send_idle_pct = 0;
		hold_off_cycles = 200;
		send_frame(16'hBEEF, 16'h0000, 16'd60, 8'h10, 66);
		send_frame(16'hCAFE, 16'h0000, 16'd30, 8'h20, 36);
		wait_for_results();
	endtask

	task automatic send_random_frame();
		logic [15:0] tid;
		logic [15:0] proto;
		logic [15:0] len;
		logic [7:0]  unit;
		int unsigned span;
		int unsigned nbytes;
		int unsigned kind;
		tid = 16'($urandom);
		unit = 8'($urandom);
		proto = 16'd0;
		len = ($urandom_range(19) == 0) ? 16'($urandom_range(MAX_ADU - 6, 2)) :
			16'($urandom_range(20, 2));
		span = 6 + len;
		nbytes = span;
		kind = $urandom_range(99);
		// most frames stay well formed; the rest get a bad protocol, length or count
		if (kind < 5) begin
			proto = 16'($urandom_range(65535, 1));
			nbytes = $urandom_range(span + 2, 7);
		end else if (kind < 12) begin
			len = $urandom_range(1) ? 16'($urandom_range(1)) :
				16'($urandom_range(65535, MAX_ADU - 5));
			nbytes = $urandom_range(30, 7);
		end else if (kind < 18) begin
			nbytes = $urandom_range(span - 1, 7);
		end else if (kind < 24) begin
			nbytes = $urandom_range(span + 8, span + 1);
		end else if (kind < 30) begin
			nbytes = $urandom_range(6, 1);
		end
		send_frame(tid, proto, len, unit, nbytes);
	endtask

	task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
			int unsigned n_bytes);
		int unsigned stop_at;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at)
			send_random_frame();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 8;
		recv_stall_pct = 55;
		test_short_frames();
		test_bad_protocol();
		test_length_limits();
		test_count_mismatch();
		test_saturated_count();
		test_random_traffic(8, 55, 230);
		test_random_traffic(55, 8, 230);
		test_backpressure();
		test_random_traffic(0, 0, 230);

		wait_for_results();
		repeat (PIPE_DRAIN) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
